@@ rtl/core/owbm_pkg.sv @@
package owbm_pkg;

   localparam int unsigned NUM_REGS = 8;
   localparam int unsigned REG_IDX_W = 3;
   localparam int unsigned TICK_W = 8;
   localparam int unsigned BIT_IDX_W = 3;
   localparam int unsigned BYTE_W = 8;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_RESET = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_RESET_LOW     = 3'd0,
      REG_PRESENCE_WAIT = 3'd1,
      REG_RESET_RECOVER = 3'd2,
      REG_SLOT_START    = 3'd3,
      REG_WRITE_HOLD    = 3'd4,
      REG_READ_SAMPLE   = 3'd5,
      REG_READ_RECOVER  = 3'd6,
      REG_SLOT_GAP      = 3'd7
   } reg_idx_type;

   typedef enum logic [8:0] {
      PH_IDLE        = 9'b000000001,
      PH_RST_LOW     = 9'b000000010,
      PH_RST_WAIT    = 9'b000000100,
      PH_RST_RECOVER = 9'b000001000,
      PH_SLOT_START  = 9'b000010000,
      PH_WRITE_HOLD  = 9'b000100000,
      PH_READ_WAIT   = 9'b001000000,
      PH_READ_RECOV  = 9'b010000000,
      PH_GAP         = 9'b100000000
   } phase_type;

   // one classified beat as it sits in the queue
   typedef struct packed {
      logic              is_tick;
      cmd_type           cmd;
      logic [BYTE_W-1:0] data;
      logic              line;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   function automatic logic [TICK_W-1:0] reg_reset_value(input reg_idx_type idx);
      logic [TICK_W-1:0] v;
      begin
         unique case (idx)
            REG_RESET_LOW:     v = 8'd96;
            REG_PRESENCE_WAIT: v = 8'd12;
            REG_RESET_RECOVER: v = 8'd96;
            REG_SLOT_START:    v = 8'd1;
            REG_WRITE_HOLD:    v = 8'd12;
            REG_READ_SAMPLE:   v = 8'd1;
            REG_READ_RECOVER:  v = 8'd10;
            REG_SLOT_GAP:      v = 8'd1;
            default:           v = 8'd1;
         endcase
         return v;
      end
   endfunction

endpackage

@@ rtl/core/owbm_channels.sv @@
interface owbm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] write_data;
   logic       line_level;

   modport source (output valid, command, write_data, line_level, input ready);
   modport sink (input valid, command, write_data, line_level, output ready);
endinterface

interface owbm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic       presence_seen;
   logic [7:0] read_data;
   logic       rejected;

   modport source (output valid, drive_low, busy_res, done_res, presence_seen, read_data,
                   rejected, input ready);
   modport sink (input valid, drive_low, busy_res, done_res, presence_seen, read_data,
                 rejected, output ready);
endinterface

interface owbm_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/owbm_front.sv @@
module owbm_front import owbm_pkg::*; (
   owbm_req_if.sink   req_bus,
   output push_type   push,
   input  logic       push_ready
);

   item_type item;

   always_comb begin
      item.cmd     = cmd_type'(req_bus.command);
      item.is_tick = (item.cmd == CMD_TICK);
      item.line    = req_bus.line_level;
      // only a write loads its byte into the shifter, read starts from zero
      item.data    = (item.cmd == CMD_WRITE) ? req_bus.write_data : '0;
   end

   assign push.valid    = req_bus.valid;
   assign push.item     = item;
   assign req_bus.ready = push_ready;

endmodule

@@ rtl/core/owbm_queue.sv @@
module owbm_queue import owbm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     push_ready,
   output head_type head,
   input  logic     pop
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && (count_ff != 2'd0);

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

@@ rtl/core/owbm_engine.sv @@
module owbm_engine import owbm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  head_type   head,
   output logic       pop,
   owbm_csr_if.sink   csr_bus,
   owbm_rsp_if.source rsp_bus
);

   logic [TICK_W-1:0]    cfg_ff [NUM_REGS];
   phase_type            phase_ff, phase_in;
   logic [TICK_W-1:0]    count_ff, count_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   logic [BYTE_W-1:0]    shift_ff, shift_in;
   logic                 pres_ff, pres_in;
   cmd_type              op_ff, op_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 drive_ff, drive_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [BYTE_W-1:0]    rdata_ff, rdata_in;
   logic                 rej_ff, rej_in;

   logic                 take;
   logic [TICK_W-1:0]    count_inc;
   logic [TICK_W-1:0]    raw_len;
   logic [TICK_W-1:0]    limit;
   logic                 gap_off;

   assign csr_bus.ready = 1'b1;
   assign take = head.valid && (!rsp_valid_ff || rsp_bus.ready);
   assign pop  = take;
   assign gap_off = (cfg_ff[REG_SLOT_GAP] == '0);
   assign count_inc = count_ff + 8'd1;

   always_comb begin
      unique case (phase_ff)
         PH_RST_LOW:     raw_len = cfg_ff[REG_RESET_LOW];
         PH_RST_WAIT:    raw_len = cfg_ff[REG_PRESENCE_WAIT];
         PH_RST_RECOVER: raw_len = cfg_ff[REG_RESET_RECOVER];
         PH_SLOT_START:  raw_len = cfg_ff[REG_SLOT_START];
         PH_WRITE_HOLD:  raw_len = cfg_ff[REG_WRITE_HOLD];
         PH_READ_WAIT:   raw_len = cfg_ff[REG_READ_SAMPLE];
         PH_READ_RECOV:  raw_len = cfg_ff[REG_READ_RECOVER];
         default:        raw_len = cfg_ff[REG_SLOT_GAP];
      endcase
      // a zero length behaves as one tick; a zero slot gap skips the gap phase
      limit = (raw_len == '0) ? 8'd1 : raw_len;
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pres_in  = pres_ff;
      op_in    = op_ff;
      done_in  = 1'b0;
      rej_in   = 1'b0;

      if (take) begin
         if (!head.item.is_tick) begin
            if (phase_ff != PH_IDLE) begin
               rej_in = 1'b1;
            end else begin
               op_in    = head.item.cmd;
               bit_in   = '0;
               count_in = '0;
               if (head.item.cmd == CMD_RESET) begin
                  pres_in  = 1'b0;
                  phase_in = PH_RST_LOW;
               end else begin
                  shift_in = head.item.data;
                  phase_in = PH_SLOT_START;
               end
            end
         end else if (phase_ff != PH_IDLE) begin
            count_in = count_inc;
            if (count_inc >= limit) begin
               count_in = '0;
               unique case (phase_ff) inside
                  PH_RST_LOW: begin
                     phase_in = PH_RST_WAIT;
                  end
                  PH_RST_WAIT: begin
                     pres_in  = ~head.item.line;
                     phase_in = PH_RST_RECOVER;
                  end
                  PH_RST_RECOVER: begin
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end
                  PH_SLOT_START: begin
                     phase_in = (op_ff == CMD_WRITE) ? PH_WRITE_HOLD : PH_READ_WAIT;
                  end
                  PH_READ_WAIT: begin
                     shift_in[bit_ff] = shift_ff[bit_ff] | head.item.line;
                     phase_in = PH_READ_RECOV;
                  end
                  PH_WRITE_HOLD, PH_READ_RECOV: begin
                     // slot end: last bit finishes, otherwise gap or next slot
                     if (bit_ff == '1) begin
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                     end else if (gap_off) begin
                        bit_in   = bit_ff + 3'd1;
                        phase_in = PH_SLOT_START;
                     end else begin
                        phase_in = PH_GAP;
                     end
                  end
                  PH_GAP: begin
                     bit_in   = bit_ff + 3'd1;
                     phase_in = PH_SLOT_START;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      end

      drive_in = (phase_in == PH_RST_LOW) || (phase_in == PH_SLOT_START) ||
                 ((phase_in == PH_WRITE_HOLD) && !shift_in[bit_in]);
      busy_in  = (phase_in != PH_IDLE);
      rdata_in = ((phase_in == PH_IDLE) && (op_in == CMD_READ)) ? shift_in : '0;

      rsp_valid_in = take ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         pres_ff      <= 1'b0;
         op_ff        <= CMD_TICK;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         pres_ff      <= pres_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[reg_idx_type'(i)] <= reg_reset_value(reg_idx_type'(i));
         end
      end else if (csr_bus.valid) begin
         cfg_ff[csr_bus.index] <= csr_bus.data;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (take) begin
         drive_ff <= drive_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         rdata_ff <= rdata_in;
         rej_ff   <= rej_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.drive_low     = drive_ff;
   assign rsp_bus.busy_res      = busy_ff;
   assign rsp_bus.done_res      = done_ff;
   assign rsp_bus.presence_seen = pres_ff;
   assign rsp_bus.read_data     = rdata_ff;
   assign rsp_bus.rejected      = rej_ff;

endmodule

@@ rtl/core/one_wire_bus_master.sv @@
// 1-Wire bus master driven by a stream of beats, each either a command (reset with
// presence detect, write byte, read byte, LSB first) or a 5 us tick carrying the
// sampled bus level; every beat returns one result beat with drive_low, busy, done,
// presence, read data and rejected. Phase lengths are eight 8-bit tick-count
// registers; the user must write them on the csr channel while the master is idle,
// which the block does not enforce. Throughput is one beat per clock while the
// result side is ready. The front decodes into a two-entry queue; the engine retires
// one beat per cycle into a registered result stage. A request beat passes through
// a queue entry and the result register; the queue absorbs a stall on either side.
module one_wire_bus_master import owbm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   owbm_req_if.sink   req_bus,
   owbm_rsp_if.source rsp_bus,
   owbm_csr_if.sink   csr_bus
);

   push_type push;
   logic     push_ready;
   head_type head;
   logic     pop;

   owbm_front u_front (
      .req_bus    (req_bus),
      .push       (push),
      .push_ready (push_ready)
   );

   owbm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   owbm_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .csr_bus (csr_bus),
      .rsp_bus (rsp_bus)
   );

endmodule
